// ===== rtl/sidasc_pkg.sv =====
// Shared constants and controller/datapath interface types for the decimal text converter.
package sidasc_pkg;

  localparam int DIGITS  = 10;
  localparam int VALUE_W = 32;
  localparam int CHAR_W  = 6;
  localparam int BCD_W   = 4 * DIGITS;
  localparam int REM_W   = $clog2(DIGITS + 1);
  localparam int CNT_W   = $clog2(VALUE_W);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);

  typedef struct packed {
    logic load;
    logic conv_step;
    logic skip_shift;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic skip_ok;
    logic negative;
    logic rem_last;
    logic slot_free;
  } sts_t;

endpackage

// ===== rtl/signed_int_to_decimal_ascii.sv =====
// Top level of the signed 32-bit integer to decimal ASCII text converter.
// After an accepted input beat, the 32-step shift-add-3 loop converts the magnitude, then
// leading zeros are suppressed (up to 9), then the sign and digits leave through the single
// output register, one character beat per cycle while out_ready holds. A new value is accepted
// only when the controller is idle again, after the last character beat has been issued.
// Reset (rst_n low, synchronous) returns the controller to idle and empties the output.
module signed_int_to_decimal_ascii (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [sidasc_pkg::VALUE_W-1:0] in_value,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [sidasc_pkg::CHAR_W-1:0]         out_character,
  output logic                                  out_last
);
  import sidasc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sidasc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sidasc_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_character (out_character),
    .out_last      (out_last)
  );

endmodule

// ===== rtl/sidasc_datapath.sv =====
// Datapath: magnitude register, shift-add-3 BCD converter, digit shifter and output register.
module sidasc_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sidasc_pkg::cmd_t               cmd,
  output sidasc_pkg::sts_t               sts,
  input  logic signed [sidasc_pkg::VALUE_W-1:0] in_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sidasc_pkg::CHAR_W-1:0]  out_character,
  output logic                           out_last
);
  import sidasc_pkg::*;

  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic               neg_r, neg_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;
  logic [BCD_W-1:0]   bcd_adj;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic               ovf_r, ovf_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;
  logic [VALUE_W-1:0] raw;
  logic [3:0]         top_digit;

  assign raw       = in_value;
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  always_comb begin
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd_r[4*d +: 4];
      end
    end
  end

  always_comb begin
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    ovf_nxt       = ovf_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load) begin
      neg_nxt = raw[VALUE_W-1];
      mag_nxt = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
      bcd_nxt = '0;
      cnt_nxt = CNT_W'(VALUE_W - 1);
      rem_nxt = REM_W'(DIGITS);
      ovf_nxt = 1'b0;
    end
    if (cmd.conv_step) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VALUE_W-1]};
      mag_nxt = {mag_r[VALUE_W-2:0], 1'b0};
      ovf_nxt = ovf_r | bcd_adj[BCD_W-1];
      cnt_nxt = cnt_r - CNT_W'(1);
    end
    if (cmd.skip_shift) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
      rem_nxt = rem_r - REM_W'(1);
    end
    if (cmd.emit_sign) begin
      out_char_nxt  = ASCII_MINUS;
      out_last_nxt  = 1'b0;
      out_valid_nxt = 1'b1;
    end
    if (cmd.emit_digit) begin
      out_char_nxt  = ASCII_ZERO + {{(CHAR_W-4){1'b0}}, top_digit};
      out_last_nxt  = (rem_r == REM_W'(1));
      out_valid_nxt = 1'b1;
      bcd_nxt       = {bcd_r[BCD_W-5:0], 4'd0};
      rem_nxt       = rem_r - REM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    rem_r      <= rem_nxt;
    ovf_r      <= ovf_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts.conv_done = (cnt_r == '0);
  assign sts.skip_ok   = (top_digit == 4'd0) && (rem_r != REM_W'(1)) && !ovf_r;
  assign sts.negative  = neg_r;
  assign sts.rem_last  = (rem_r == REM_W'(1));
  assign sts.slot_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

// ===== rtl/sidasc_ctrl.sv =====
// Controller state machine that sequences load, conversion, zero skipping and character beats.
module sidasc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sidasc_pkg::sts_t sts,
  output sidasc_pkg::cmd_t cmd
);
  import sidasc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_SKIP  = 3'd2;
  localparam logic [2:0] ST_SIGN  = 3'd3;
  localparam logic [2:0] ST_DIGIT = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_done) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (sts.skip_ok) begin
          cmd.skip_shift = 1'b1;
        end else if (sts.negative) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (sts.slot_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts.slot_free) begin
          cmd.emit_digit = 1'b1;
          if (sts.rem_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/sidasc_checker.sv =====
// Port-level checker for the decimal text converter and its bind to the top level.
module sidasc_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic signed [sidasc_pkg::VALUE_W-1:0] in_value,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [sidasc_pkg::CHAR_W-1:0]         out_character,
  input logic                                  out_last
);
  import sidasc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) && $stable(out_last))
    else $error("Stalled output beat changed or dropped.");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_character == ASCII_MINUS ||
                  (out_character >= ASCII_ZERO && out_character <= ASCII_ZERO + CHAR_W'(9)))
    else $error("Output character is neither a digit nor a minus sign.");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_character == ASCII_MINUS |-> !out_last)
    else $error("Minus sign flagged as the last character.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Input accepted again while a conversion is running.");

endmodule

bind signed_int_to_decimal_ascii sidasc_checker u_sidasc_checker (.*);
